// ===== rtl/bpis_pkg.sv =====
package bpis_pkg;

    // Default sizes of the stores
    localparam int NUM_TAPS_DEF       = 31;
    localparam int MAX_IN_SAMPLES_DEF = 512;
    localparam int MAX_CHANNELS_DEF   = 16;
    localparam int MAX_POINTS_DEF     = 4096;

    // Port widths
    localparam int TDATA_IN_W  = 56;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 32;
    localparam int TUSER_OUT_W = 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    // Datapath widths
    localparam int ACC_W = 40;
    localparam int UPS_W = 32;

    typedef enum logic [1:0] {
        OP_TAP  = 2'd0,
        OP_MAP  = 2'd1,
        OP_PUSH = 2'd2,
        OP_READ = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_NUM_CHANNELS = 2'd0,
        REG_IN_SAMPLES   = 2'd1,
        REG_UP_FACTOR    = 2'd2,
        REG_OUT_STEP     = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CMD_TAP,
        CMD_MAP,
        CMD_PUSH,
        CMD_READ,
        CMD_READ_ZERO
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [3:0]         channel;
        logic [11:0]        index;
        logic signed [15:0] coeff_value;
        logic [11:0]        map_target;
        logic signed [7:0]  sample_value;
    } cmd_t;

    typedef struct packed {
        logic [4:0] num_channels;
        logic [9:0] in_samples;
        logic [3:0] up_factor;
        logic [3:0] out_step;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic clearing;
    } back_status_t;

endpackage

// ===== rtl/bpis_front.sv =====
module bpis_front #(
    parameter int NUM_TAPS     = bpis_pkg::NUM_TAPS_DEF,
    parameter int MAX_CHANNELS = bpis_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_POINTS   = bpis_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpis_pkg::TDATA_IN_W-1:0] s_tdata,
    input  logic [bpis_pkg::TUSER_IN_W-1:0] s_tuser,
    output logic                            cmd_valid,
    output bpis_pkg::cmd_t                  cmd,
    input  bpis_pkg::back_status_t          status
);

    bpis_pkg::op_t  op;
    bpis_pkg::cmd_t item;
    logic           keep;
    logic           ch_ok;
    logic           idx_ok;
    logic           push;
    logic           pop;

    bpis_pkg::cmd_t q_reg [2];
    logic [1:0]     cnt_reg;
    logic           rd_reg;
    logic           wr_reg;

    // Unpack and classify the incoming item
    always_comb
    begin
        op                = bpis_pkg::op_t'(s_tuser);
        item.channel      = s_tdata[3:0];
        item.index        = s_tdata[15:4];
        item.coeff_value  = s_tdata[31:16];
        item.map_target   = s_tdata[43:32];
        item.sample_value = s_tdata[51:44];
        ch_ok             = int'(item.channel) < MAX_CHANNELS;
        idx_ok            = int'(item.index) < MAX_POINTS;
        unique case (op)
            bpis_pkg::OP_TAP:
            begin
                item.kind = bpis_pkg::CMD_TAP;
                keep      = int'(item.index) < NUM_TAPS;
            end
            bpis_pkg::OP_MAP:
            begin
                item.kind = bpis_pkg::CMD_MAP;
                keep      = ch_ok && idx_ok;
            end
            bpis_pkg::OP_PUSH:
            begin
                item.kind = bpis_pkg::CMD_PUSH;
                keep      = ch_ok;
            end
            bpis_pkg::OP_READ:
            begin
                item.kind = idx_ok ? bpis_pkg::CMD_READ : bpis_pkg::CMD_READ_ZERO;
                keep      = 1'b1;
            end
            default:
            begin
                item.kind = bpis_pkg::CMD_READ_ZERO;
                keep      = 1'b0;
            end
        endcase
    end

    assign s_tready  = (cnt_reg != 2'd2) && !status.clearing;
    assign push      = s_tvalid && s_tready && keep;
    assign pop       = status.take;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rd_reg];

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= item;
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/bpis_back.sv =====
module bpis_back #(
    parameter int NUM_TAPS       = bpis_pkg::NUM_TAPS_DEF,
    parameter int MAX_IN_SAMPLES = bpis_pkg::MAX_IN_SAMPLES_DEF,
    parameter int MAX_CHANNELS   = bpis_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_POINTS     = bpis_pkg::MAX_POINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bpis_pkg::cfg_t                   cfg,
    input  logic                             cmd_valid,
    input  bpis_pkg::cmd_t                   cmd,
    output bpis_pkg::back_status_t           status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bpis_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic [bpis_pkg::TUSER_OUT_W-1:0] m_tuser
);

    localparam int CW      = $clog2(MAX_IN_SAMPLES + 1);
    localparam int SW      = $clog2(MAX_IN_SAMPLES);
    localparam int UPD     = MAX_IN_SAMPLES * 8;
    localparam int UPW     = $clog2(UPD);
    localparam int UW      = $clog2(UPD + 1);
    localparam int POSW    = UW + 1;
    localparam int TPP_MAX = NUM_TAPS / 2 + 1;
    localparam int TW      = $clog2(TPP_MAX + 1);
    localparam int HW      = TW + 4;
    localparam int TIW     = $clog2(NUM_TAPS + 17);
    localparam int TAW     = $clog2(NUM_TAPS);
    localparam int PAW     = $clog2(MAX_POINTS);
    localparam int PW      = $clog2(MAX_POINTS + 1);
    localparam int FMD     = MAX_CHANNELS * MAX_POINTS;
    localparam int FAW     = $clog2(FMD);
    localparam int SIW     = CW + 2;
    localparam int AW      = bpis_pkg::ACC_W;
    localparam int DCW     = $clog2(AW);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_BASE_RD,
        S_BASE_WR,
        S_MAC,
        S_DRAIN,
        S_GMAP,
        S_GUPS,
        S_GACC,
        S_RRD,
        S_RLOAD,
        S_RDIV,
        S_RQUO,
        S_ROUT
    } state_t;

    state_t state_reg;

    // Memories
    logic signed [15:0]             tap_mem   [NUM_TAPS];
    logic signed [7:0]              smp_mem   [MAX_IN_SAMPLES];
    logic signed [bpis_pkg::UPS_W-1:0] ups_mem [UPD];
    logic [11:0]                    fm_mem    [FMD];
    logic signed [AW-1:0]           acc_mem   [MAX_POINTS];

    // Clamped configuration
    logic [4:0]    nc_cl;
    logic [CW-1:0] n_cl;
    logic [3:0]    u_cl;
    logic [3:0]    step_cl;
    logic [TW-1:0] tpp_c;
    logic [HW-1:0] half_c;
    logic [CW-1:0] k_c;
    logic [POSW-1:0] kend_c;
    logic [POSW-1:0] ups_c;

    // Sequencer registers
    logic [CW-1:0]   cnt_reg;
    logic [3:0]      ch_reg;
    logic [3:0]      u_reg;
    logic [3:0]      step_reg;
    logic [TW-1:0]   tpp_reg;
    logic [HW-1:0]   half_reg;
    logic [CW-1:0]   k_reg;
    logic [POSW-1:0] kend_reg;
    logic [POSW-1:0] ups_reg;
    logic [CW-1:0]   j_reg;
    logic [UW-1:0]   base_reg;
    logic [3:0]      s_reg;
    logic [TW-1:0]   t_reg;
    logic signed [SIW-1:0] si_reg;
    logic [TIW-1:0]  tix_reg;
    logic signed [31:0] mac_reg;
    logic signed [15:0] tap_q_reg;
    logic            z1_reg;
    logic            v1_reg;
    logic            v2_reg;
    logic signed [23:0] prod_reg;
    logic [PW-1:0]   p_reg;
    logic [POSW-1:0] pos_reg;
    logic            inreg_reg;
    logic [11:0]     idx_reg;
    logic            neg_reg;
    logic [AW-1:0]   dvd_reg;
    logic [5:0]      rem_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic signed [AW:0] q_reg;
    logic            zread_reg;
    logic [PW-1:0]   clr_reg;
    logic            m_tvalid_reg;
    logic [31:0]     m_tdata_reg;
    logic            m_tuser_reg;

    // Memory read data
    logic signed [7:0]  smp_rd_reg;
    logic signed [bpis_pkg::UPS_W-1:0] ups_rd_reg;
    logic [11:0]        fm_rd_reg;
    logic signed [AW-1:0] acc_rd_reg;

    // Memory port controls
    logic            smp_we;
    logic [SW-1:0]   smp_wa;
    logic [SW-1:0]   smp_ra;
    logic            ups_we;
    logic [UPW-1:0]  ups_wa;
    logic signed [bpis_pkg::UPS_W-1:0] ups_wd;
    logic [UPW-1:0]  ups_ra;
    logic            fm_we;
    logic [FAW-1:0]  fm_wa;
    logic [FAW-1:0]  fm_ra;
    logic            acc_we;
    logic [PAW-1:0]  acc_wa;
    logic signed [AW-1:0] acc_wd;
    logic [PAW-1:0]  acc_ra;

    logic [CW:0]     cnt_inc;
    logic            take;
    logic            out_free;
    logic            mac_last;
    logic            drain_done;
    logic [CW-1:0]   j_inc;
    logic [PW-1:0]   p_inc;
    logic [POSW-1:0] pos_inc;
    logic signed [AW:0] gsum;
    logic signed [AW-1:0] gsat;
    logic signed [SIW-1:0] si_start;
    logic [5:0]      dsh;
    logic            dbit;
    logic [AW+1:0]   rsum;
    logic [33:0]     rshift;
    logic            rsat;
    logic [31:0]     rval;
    logic signed [15:0] tap_sel;

    // Clamp the configuration and derive the upsampling geometry
    always_comb
    begin
        nc_cl   = (cfg.num_channels == 5'd0) ? 5'd1 : cfg.num_channels;
        if (cfg.in_samples == 10'd0)
        begin
            n_cl = CW'(1);
        end
        else if (int'(cfg.in_samples) > MAX_IN_SAMPLES)
        begin
            n_cl = CW'(MAX_IN_SAMPLES);
        end
        else
        begin
            n_cl = CW'(cfg.in_samples);
        end
        if (cfg.up_factor < 4'd2)
        begin
            u_cl = 4'd2;
        end
        else if (cfg.up_factor > 4'd8)
        begin
            u_cl = 4'd8;
        end
        else
        begin
            u_cl = cfg.up_factor;
        end
        step_cl = (cfg.out_step == 4'd0) ? 4'd1 : cfg.out_step;
        unique case (u_cl)
            4'd2:    tpp_c = TW'(NUM_TAPS / 2 + 1);
            4'd3:    tpp_c = TW'(NUM_TAPS / 3 + 1);
            4'd4:    tpp_c = TW'(NUM_TAPS / 4 + 1);
            4'd5:    tpp_c = TW'(NUM_TAPS / 5 + 1);
            4'd6:    tpp_c = TW'(NUM_TAPS / 6 + 1);
            4'd7:    tpp_c = TW'(NUM_TAPS / 7 + 1);
            default: tpp_c = TW'(NUM_TAPS / 8 + 1);
        endcase
        half_c = HW'((HW'(tpp_c) * HW'(u_cl)) >> 1);
        k_c    = (n_cl > CW'(tpp_c)) ? (n_cl - CW'(tpp_c)) : CW'(0);
        kend_c = POSW'(half_c) + POSW'(POSW'(k_c) * POSW'(u_cl));
        ups_c  = POSW'(POSW'(n_cl) * POSW'(u_cl));
    end

    assign take       = (state_reg == S_IDLE) && cmd_valid;
    assign status     = '{take: take, clearing: (state_reg == S_CLEAR)};
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cnt_inc    = {1'b0, cnt_reg} + (CW + 1)'(1);
    assign mac_last   = t_reg == (tpp_reg - TW'(1));
    assign drain_done = !v1_reg && !v2_reg;
    assign j_inc      = j_reg + CW'(1);
    assign p_inc      = p_reg + PW'(1);
    assign pos_inc    = pos_reg + POSW'(step_reg);
    assign si_start   = $signed({2'b00, j_reg}) - $signed(SIW'(u_reg)) + SIW'(1);
    assign tap_sel    = (int'(tix_reg) < NUM_TAPS) ? tap_mem[TAW'(tix_reg)] : 16'sd0;

    // Saturating accumulate of one gathered value
    always_comb
    begin
        gsum = {acc_rd_reg[AW-1], acc_rd_reg}
             + (inreg_reg ? (AW + 1)'(ups_rd_reg) : '0);
        if (gsum[AW] != gsum[AW-1])
        begin
            gsat = gsum[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
        end
        else
        begin
            gsat = gsum[AW-1:0];
        end
    end

    // One restoring division step
    always_comb
    begin
        dsh  = {rem_reg[4:0], dvd_reg[AW-1]};
        dbit = dsh >= {1'b0, nc_cl};
    end

    // Round Q.15 to Q.7 and saturate
    always_comb
    begin
        rsum   = {q_reg[AW], q_reg} + (AW + 2)'(128);
        rshift = rsum[AW+1:8];
        rsat   = (rshift[33:31] != 3'b000) && (rshift[33:31] != 3'b111);
        if (rsat)
        begin
            rval = rshift[33] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        else
        begin
            rval = rshift[31:0];
        end
    end

    // Memory port selection
    always_comb
    begin
        smp_we = take && (cmd.kind == bpis_pkg::CMD_PUSH)
               && (int'(cnt_reg) < MAX_IN_SAMPLES);
        smp_wa = SW'(cnt_reg);
        smp_ra = (state_reg == S_BASE_RD) ? SW'(j_reg) : SW'(si_reg);

        ups_we = 1'b0;
        ups_wa = UPW'(base_reg);
        ups_wd = {{9{smp_rd_reg[7]}}, smp_rd_reg, 15'd0};
        if (state_reg == S_BASE_WR)
        begin
            ups_we = 1'b1;
        end
        else if ((state_reg == S_DRAIN) && drain_done)
        begin
            ups_we = 1'b1;
            ups_wa = UPW'(base_reg + UW'(s_reg));
            ups_wd = mac_reg;
        end
        ups_ra = UPW'(fm_rd_reg);

        fm_we = take && (cmd.kind == bpis_pkg::CMD_MAP);
        fm_wa = FAW'(int'(cmd.channel) * MAX_POINTS + int'(cmd.index));
        fm_ra = FAW'(int'(ch_reg) * MAX_POINTS) + FAW'(p_reg);

        acc_we = 1'b0;
        acc_wa = PAW'(p_reg);
        acc_wd = gsat;
        if (state_reg == S_CLEAR)
        begin
            acc_we = 1'b1;
            acc_wa = PAW'(clr_reg);
            acc_wd = '0;
        end
        else if (state_reg == S_GACC)
        begin
            acc_we = 1'b1;
        end
        else if ((state_reg == S_ROUT) && out_free && !zread_reg)
        begin
            acc_we = 1'b1;
            acc_wa = PAW'(idx_reg);
            acc_wd = '0;
        end
        acc_ra = (state_reg == S_RRD) ? PAW'(idx_reg) : PAW'(p_reg);
    end

    // Tap store
    always_ff @(posedge clk)
    begin
        if (take && (cmd.kind == bpis_pkg::CMD_TAP))
        begin
            tap_mem[TAW'(cmd.index)] <= cmd.coeff_value;
        end
    end

    // Sample store
    always_ff @(posedge clk)
    begin
        if (smp_we)
        begin
            smp_mem[smp_wa] <= cmd.sample_value;
        end
        smp_rd_reg <= smp_mem[smp_ra];
    end

    // Upsampled vector store
    always_ff @(posedge clk)
    begin
        if (ups_we)
        begin
            ups_mem[ups_wa] <= ups_wd;
        end
        ups_rd_reg <= ups_mem[ups_ra];
    end

    // Focus map store
    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            fm_mem[fm_wa] <= cmd.map_target;
        end
        fm_rd_reg <= fm_mem[fm_ra];
    end

    // Point accumulator store
    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_wa] <= acc_wd;
        end
        acc_rd_reg <= acc_mem[acc_ra];
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            ch_reg       <= '0;
            u_reg        <= 4'd2;
            step_reg     <= 4'd1;
            tpp_reg      <= '0;
            half_reg     <= '0;
            k_reg        <= '0;
            kend_reg     <= '0;
            ups_reg      <= '0;
            j_reg        <= '0;
            base_reg     <= '0;
            s_reg        <= '0;
            t_reg        <= '0;
            si_reg       <= '0;
            tix_reg      <= '0;
            mac_reg      <= '0;
            tap_q_reg    <= '0;
            z1_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            prod_reg     <= '0;
            p_reg        <= '0;
            pos_reg      <= '0;
            inreg_reg    <= 1'b0;
            idx_reg      <= '0;
            neg_reg      <= 1'b0;
            dvd_reg      <= '0;
            rem_reg      <= '0;
            dcnt_reg     <= '0;
            q_reg        <= '0;
            zread_reg    <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            // Multiply-accumulate pipeline
            v1_reg   <= 1'b0;
            v2_reg   <= v1_reg;
            prod_reg <= (z1_reg ? 8'sd0 : smp_rd_reg) * tap_q_reg;
            if (v2_reg)
            begin
                mac_reg <= mac_reg + {{8{prod_reg[23]}}, prod_reg};
            end

            // Drop a result once taken
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + PW'(1);
                    if (clr_reg == PW'(MAX_POINTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        unique case (cmd.kind)
                            bpis_pkg::CMD_PUSH:
                            begin
                                if (cnt_inc >= {1'b0, n_cl})
                                begin
                                    cnt_reg   <= '0;
                                    ch_reg    <= cmd.channel;
                                    state_reg <= S_PREP;
                                end
                                else
                                begin
                                    cnt_reg <= cnt_inc[CW-1:0];
                                end
                            end
                            bpis_pkg::CMD_READ:
                            begin
                                idx_reg   <= cmd.index;
                                zread_reg <= 1'b0;
                                state_reg <= S_RRD;
                            end
                            bpis_pkg::CMD_READ_ZERO:
                            begin
                                q_reg     <= '0;
                                zread_reg <= 1'b1;
                                state_reg <= S_ROUT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PREP:
                begin
                    u_reg    <= u_cl;
                    step_reg <= step_cl;
                    tpp_reg  <= tpp_c;
                    half_reg <= half_c;
                    k_reg    <= k_c;
                    kend_reg <= kend_c;
                    ups_reg  <= ups_c;
                    j_reg    <= '0;
                    base_reg <= UW'(half_c);
                    p_reg    <= '0;
                    pos_reg  <= '0;
                    state_reg <= (k_c == '0) ? S_GMAP : S_BASE_RD;
                end
                S_BASE_RD:
                begin
                    state_reg <= S_BASE_WR;
                end
                S_BASE_WR:
                begin
                    s_reg     <= 4'd1;
                    t_reg     <= '0;
                    si_reg    <= si_start;
                    tix_reg   <= TIW'(u_reg - 4'd2);
                    mac_reg   <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    tap_q_reg <= tap_sel;
                    z1_reg    <= si_reg < 0;
                    v1_reg    <= 1'b1;
                    t_reg     <= t_reg + TW'(1);
                    si_reg    <= si_reg + SIW'(1);
                    tix_reg   <= tix_reg + TIW'(u_reg);
                    if (mac_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (drain_done)
                    begin
                        mac_reg <= '0;
                        if (s_reg == (u_reg - 4'd1))
                        begin
                            j_reg    <= j_inc;
                            base_reg <= base_reg + UW'(u_reg);
                            state_reg <= (j_inc == k_reg) ? S_GMAP : S_BASE_RD;
                        end
                        else
                        begin
                            s_reg     <= s_reg + 4'd1;
                            t_reg     <= '0;
                            si_reg    <= si_start;
                            tix_reg   <= TIW'(u_reg - 4'd2 - s_reg);
                            state_reg <= S_MAC;
                        end
                    end
                end
                S_GMAP:
                begin
                    state_reg <= S_GUPS;
                end
                S_GUPS:
                begin
                    inreg_reg <= (POSW'(fm_rd_reg) >= POSW'(half_reg))
                              && (POSW'(fm_rd_reg) < kend_reg);
                    state_reg <= S_GACC;
                end
                S_GACC:
                begin
                    p_reg   <= p_inc;
                    pos_reg <= pos_inc;
                    if ((p_inc == PW'(MAX_POINTS)) || (pos_inc >= ups_reg))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_GMAP;
                    end
                end
                S_RRD:
                begin
                    state_reg <= S_RLOAD;
                end
                S_RLOAD:
                begin
                    neg_reg   <= acc_rd_reg[AW-1];
                    dvd_reg   <= acc_rd_reg[AW-1] ? (~acc_rd_reg + AW'(1)) : acc_rd_reg;
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= S_RDIV;
                end
                S_RDIV:
                begin
                    rem_reg  <= dbit ? (dsh - {1'b0, nc_cl}) : dsh;
                    dvd_reg  <= {dvd_reg[AW-2:0], dbit};
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (dcnt_reg == DCW'(AW - 1))
                    begin
                        state_reg <= S_RQUO;
                    end
                end
                S_RQUO:
                begin
                    q_reg     <= neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
                    state_reg <= S_ROUT;
                end
                S_ROUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= rval;
                        m_tuser_reg  <= rsat;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/beamform_polyphase_interp_sum_unit.sv =====
// Delay-and-sum beamformer with a polyphase upsampler. Items carry an op in
// s_tuser: load a tap, load a focus-map entry, push a sample, or read one point.
// A two-entry command queue decouples the input from the executing sequencer.
// Tap, map and ordinary push items are taken in the idle state. The push that
// completes a channel vector starts processing on the single multiply-accumulate
// unit, which computes U-1 phases of T taps for each of K base samples
// (K = samples - T, U = up_factor, T = NUM_TAPS/U + 1), followed by a gather of
// each output point through the focus-map, upsampled-vector and accumulator
// memories. A point read divides by the channel count in a one-bit-per-cycle
// divider. After reset a clearing pass zeroes the accumulators, during which
// s_tready stays low; configuration writes are taken at any time.
module beamform_polyphase_interp_sum_unit #(
    parameter int NUM_TAPS       = bpis_pkg::NUM_TAPS_DEF,
    parameter int MAX_IN_SAMPLES = bpis_pkg::MAX_IN_SAMPLES_DEF,
    parameter int MAX_CHANNELS   = bpis_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_POINTS     = bpis_pkg::MAX_POINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // channel[3:0], index[15:4], coeff_value[31:16], map_target[43:32],
    // sample_value[51:44], zero[55:52]
    input  logic [bpis_pkg::TDATA_IN_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [bpis_pkg::TUSER_IN_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // point_value[31:0]
    output logic [bpis_pkg::TDATA_OUT_W-1:0] m_tdata,
    // saturated[0]
    output logic [bpis_pkg::TUSER_OUT_W-1:0] m_tuser,
    input  logic                             cfg_we,
    input  logic [bpis_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpis_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bpis_pkg::cfg_t         cfg_reg;
    bpis_pkg::cmd_t         cmd;
    logic                   cmd_valid;
    bpis_pkg::back_status_t status;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_channels <= 5'd1;
            cfg_reg.in_samples   <= 10'd512;
            cfg_reg.up_factor    <= 4'd4;
            cfg_reg.out_step     <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (bpis_pkg::cfg_reg_t'(cfg_index))
                bpis_pkg::REG_NUM_CHANNELS: cfg_reg.num_channels <= cfg_data[4:0];
                bpis_pkg::REG_IN_SAMPLES:   cfg_reg.in_samples   <= cfg_data[9:0];
                bpis_pkg::REG_UP_FACTOR:    cfg_reg.up_factor    <= cfg_data[3:0];
                bpis_pkg::REG_OUT_STEP:     cfg_reg.out_step     <= cfg_data[3:0];
                default:                    cfg_reg.out_step     <= cfg_reg.out_step;
            endcase
        end
    end

    bpis_front #(
        .NUM_TAPS    (NUM_TAPS),
        .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_POINTS  (MAX_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .status   (status)
    );

    bpis_back #(
        .NUM_TAPS      (NUM_TAPS),
        .MAX_IN_SAMPLES(MAX_IN_SAMPLES),
        .MAX_CHANNELS  (MAX_CHANNELS),
        .MAX_POINTS    (MAX_POINTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/bpis_chk.sv =====
module bpis_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bpis_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic [bpis_pkg::TUSER_OUT_W-1:0] m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A clipped point sits at a 32-bit bound
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == 32'h7fff_ffff) || (m_tdata == 32'h8000_0000))
        else $error("saturated flag without a bound value");

    // Accumulator clearing blocks input right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !s_tready)
        else $error("input accepted during clearing pass");

endmodule

bind beamform_polyphase_interp_sum_unit bpis_chk u_bpis_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
